// ===== hw/rtl/png_chunk_stream_validator_defines.svh =====
// assertion macros for the png chunk stream validator rtl
`ifndef PNG_CHUNK_STREAM_VALIDATOR_DEFINES_SVH
`define PNG_CHUNK_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PNGCSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PNGCSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pngcsv_pkg.sv =====
`timescale 1ns / 1ps

package pngcsv_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 3;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_INDEX_W = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FILE_BYTES   = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] MAX_CHUNK_LENGTH_RESET = 32'd40960;
  localparam logic [CFG_W-1:0] MAX_FILE_BYTES_RESET   = 32'd41943040;

  // parse phases, also used as byte roles
  localparam logic [CODE_W-1:0] PH_SIG  = 3'd0;
  localparam logic [CODE_W-1:0] PH_LEN  = 3'd1;
  localparam logic [CODE_W-1:0] PH_TYPE = 3'd2;
  localparam logic [CODE_W-1:0] PH_DATA = 3'd3;
  localparam logic [CODE_W-1:0] PH_CRC  = 3'd4;
  localparam logic [CODE_W-1:0] ROLE_IGNORED = 3'd5;

  // status codes
  localparam logic [CODE_W-1:0] ST_BUSY       = 3'd0;
  localparam logic [CODE_W-1:0] ST_DONE       = 3'd1;
  localparam logic [CODE_W-1:0] ST_BADSIG     = 3'd2;
  localparam logic [CODE_W-1:0] ST_CHUNK_LONG = 3'd3;
  localparam logic [CODE_W-1:0] ST_FILE_LONG  = 3'd4;
  localparam logic [CODE_W-1:0] ST_TRUNC      = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_candidate;
    logic              stream_end;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_echo;
    logic [CODE_W-1:0]  byte_role;
    logic [CODE_W-1:0]  status;
    logic [COUNT_W-1:0] bytes_accepted;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_chunk_length;
    logic [CFG_W-1:0] max_file_bytes;
  } limits_t;

  // png file signature, one byte per position
  function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] pos);
    logic [BYTE_W-1:0] v;
    case (pos)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  // end chunk type tag
  function automatic logic [BYTE_W-1:0] iend_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] v;
    case (pos)
      2'd0:    v = 8'h49;
      2'd1:    v = 8'h45;
      2'd2:    v = 8'h4E;
      default: v = 8'h44;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/pngcsv_item_if.sv =====
`timescale 1ns / 1ps

interface pngcsv_item_if;
  logic                          valid;
  logic                          ready;
  logic [pngcsv_pkg::BYTE_W-1:0] data_byte;
  logic                          start_candidate;
  logic                          stream_end;

  modport source (output valid, output data_byte, output start_candidate,
                  output stream_end, input ready);
  modport sink (input valid, input data_byte, input start_candidate,
                input stream_end, output ready);
endinterface

// ===== hw/rtl/pngcsv_result_if.sv =====
`timescale 1ns / 1ps

interface pngcsv_result_if;
  logic                           valid;
  logic                           ready;
  logic [pngcsv_pkg::BYTE_W-1:0]  byte_echo;
  logic [pngcsv_pkg::CODE_W-1:0]  byte_role;
  logic [pngcsv_pkg::CODE_W-1:0]  status;
  logic [pngcsv_pkg::COUNT_W-1:0] bytes_accepted;

  modport source (output valid, output byte_echo, output byte_role,
                  output status, output bytes_accepted, input ready);
  modport sink (input valid, input byte_echo, input byte_role,
                input status, input bytes_accepted, output ready);
endinterface

// ===== hw/rtl/png_chunk_stream_validator.sv =====
// png chunk stream validator: one result per input byte
// a result is registered and shown in the cycle after its byte transfers
// throughput: one byte per cycle unless a waiting result holds off input; the parse state updates on each transfer
// a waiting result holds off input; a byte still enters in the cycle its result leaves
// reset (rst, synchronous): parser idle, limits to 40960 and 41943040
`timescale 1ns / 1ps

module png_chunk_stream_validator (
  input  logic                               clk,
  input  logic                               rst,
  pngcsv_item_if.sink                        item,
  pngcsv_result_if.source                    result,
  input  logic                               cfg_we,
  input  logic [pngcsv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pngcsv_pkg::CFG_W-1:0]       cfg_data
);

  pngcsv_pkg::limits_t limits;
  pngcsv_pkg::item_t   in_item;
  pngcsv_pkg::result_t step_res;
  pngcsv_pkg::result_t res_reg;
  logic                res_valid;
  logic                step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_chunk_length <= pngcsv_pkg::MAX_CHUNK_LENGTH_RESET;
      limits.max_file_bytes   <= pngcsv_pkg::MAX_FILE_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pngcsv_pkg::REG_MAX_CHUNK_LENGTH: limits.max_chunk_length <= cfg_data;
        pngcsv_pkg::REG_MAX_FILE_BYTES:   limits.max_file_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input transfer
  assign item.ready = !res_valid || result.ready;
  assign step       = item.valid && item.ready;

  assign in_item.data_byte       = item.data_byte;
  assign in_item.start_candidate = item.start_candidate;
  assign in_item.stream_end      = item.stream_end;

  pngcsv_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .limits (limits),
    .res    (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= step_res;
    end
  end

  assign result.valid          = res_valid;
  assign result.byte_echo      = res_reg.byte_echo;
  assign result.byte_role      = res_reg.byte_role;
  assign result.status         = res_reg.status;
  assign result.bytes_accepted = res_reg.bytes_accepted;

endmodule

// ===== hw/rtl/pngcsv_parser.sv =====
`timescale 1ns / 1ps
`include "png_chunk_stream_validator_defines.svh"

module pngcsv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pngcsv_pkg::item_t   item,
  input  pngcsv_pkg::limits_t limits,
  output pngcsv_pkg::result_t res
);

  // parse state
  logic                           active;
  logic [pngcsv_pkg::CODE_W-1:0]  phase;
  logic [2:0]                     field_position;
  logic [pngcsv_pkg::COUNT_W-1:0] chunk_length;
  logic [pngcsv_pkg::COUNT_W-1:0] data_remaining;
  logic [pngcsv_pkg::COUNT_W-1:0] byte_total;
  logic                           type_is_end;

  logic                           active_next;
  logic [pngcsv_pkg::CODE_W-1:0]  phase_next;
  logic [2:0]                     field_position_next;
  logic [pngcsv_pkg::COUNT_W-1:0] chunk_length_next;
  logic [pngcsv_pkg::COUNT_W-1:0] data_remaining_next;
  logic [pngcsv_pkg::COUNT_W-1:0] byte_total_next;
  logic                           type_is_end_next;

  logic [pngcsv_pkg::COUNT_W-1:0] total_inc;
  logic                           decided;
  logic [pngcsv_pkg::CODE_W-1:0]  status;
  logic [pngcsv_pkg::CODE_W-1:0]  role;

  // one byte of parsing
  always_comb begin
    active_next         = active;
    phase_next          = phase;
    field_position_next = field_position;
    chunk_length_next   = chunk_length;
    data_remaining_next = data_remaining;
    byte_total_next     = byte_total;
    type_is_end_next    = type_is_end;
    status  = pngcsv_pkg::ST_BUSY;
    decided = 1'b0;

    // restart clears the parse
    if (item.start_candidate) begin
      active_next         = 1'b1;
      phase_next          = pngcsv_pkg::PH_SIG;
      field_position_next = 3'd0;
      chunk_length_next   = '0;
      data_remaining_next = '0;
      byte_total_next     = '0;
      type_is_end_next    = 1'b0;
    end

    // saturating count of the byte
    total_inc = (&byte_total_next) ? byte_total_next
                                   : byte_total_next + 32'd1;
    role = active_next ? phase_next : pngcsv_pkg::ROLE_IGNORED;

    if (active_next) begin
      case (phase_next)
        pngcsv_pkg::PH_SIG: begin
          if (item.data_byte != pngcsv_pkg::sig_byte(field_position_next)) begin
            status  = pngcsv_pkg::ST_BADSIG;
            decided = 1'b1;
          end else begin
            byte_total_next = total_inc;
            if (field_position_next == 3'd7) begin
              phase_next          = pngcsv_pkg::PH_LEN;
              field_position_next = 3'd0;
            end else begin
              field_position_next = field_position_next + 3'd1;
            end
          end
        end
        pngcsv_pkg::PH_LEN: begin
          if (field_position_next == 3'd0 &&
              byte_total_next >= limits.max_file_bytes) begin
            status  = pngcsv_pkg::ST_FILE_LONG;
            decided = 1'b1;
          end else begin
            chunk_length_next = {chunk_length_next[23:0], item.data_byte};
            byte_total_next   = total_inc;
            if (field_position_next == 3'd3) begin
              phase_next          = pngcsv_pkg::PH_TYPE;
              field_position_next = 3'd0;
            end else begin
              field_position_next = field_position_next + 3'd1;
            end
          end
        end
        pngcsv_pkg::PH_TYPE: begin
          if (field_position_next == 3'd0) begin
            type_is_end_next = (item.data_byte == pngcsv_pkg::iend_byte(2'd0));
          end else begin
            type_is_end_next = type_is_end_next &&
              (item.data_byte == pngcsv_pkg::iend_byte(field_position_next[1:0]));
          end
          if (field_position_next >= 3'd3) begin
            if (chunk_length_next >= limits.max_chunk_length) begin
              status  = pngcsv_pkg::ST_CHUNK_LONG;
              decided = 1'b1;
            end else begin
              byte_total_next     = total_inc;
              data_remaining_next = chunk_length_next;
              phase_next = (chunk_length_next != '0) ? pngcsv_pkg::PH_DATA
                                                     : pngcsv_pkg::PH_CRC;
              field_position_next = 3'd0;
            end
          end else begin
            byte_total_next     = total_inc;
            field_position_next = field_position_next + 3'd1;
          end
        end
        pngcsv_pkg::PH_DATA: begin
          byte_total_next = total_inc;
          if (data_remaining_next != '0) begin
            data_remaining_next = data_remaining_next - 32'd1;
          end
          if (data_remaining_next == '0) begin
            phase_next          = pngcsv_pkg::PH_CRC;
            field_position_next = 3'd0;
          end
        end
        default: begin
          byte_total_next = total_inc;
          if (field_position_next == 3'd3) begin
            field_position_next = 3'd0;
            if (type_is_end_next) begin
              status  = pngcsv_pkg::ST_DONE;
              decided = 1'b1;
            end else begin
              phase_next        = pngcsv_pkg::PH_LEN;
              chunk_length_next = '0;
            end
          end else begin
            field_position_next = field_position_next + 3'd1;
          end
        end
      endcase

      // early end of stream
      if (!decided && item.stream_end) begin
        status  = pngcsv_pkg::ST_TRUNC;
        decided = 1'b1;
      end
      if (decided) begin
        active_next = 1'b0;
      end
    end

    res.byte_echo      = item.data_byte;
    res.byte_role      = role;
    res.status         = status;
    res.bytes_accepted = byte_total_next;
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      phase          <= pngcsv_pkg::PH_SIG;
      field_position <= 3'd0;
      chunk_length   <= '0;
      data_remaining <= '0;
      byte_total     <= '0;
      type_is_end    <= 1'b0;
    end else if (step) begin
      active         <= active_next;
      phase          <= phase_next;
      field_position <= field_position_next;
      chunk_length   <= chunk_length_next;
      data_remaining <= data_remaining_next;
      byte_total     <= byte_total_next;
      type_is_end    <= type_is_end_next;
    end
  end

  // checks
  `PNGCSV_ASSERT_NEXT(a_end_goes_idle,
    step && res.status != pngcsv_pkg::ST_BUSY, !active,
    "parser still active after a final status")
  `PNGCSV_ASSERT_NEXT(a_idle_holds_total,
    step && !active && !item.start_candidate, $stable(byte_total),
    "byte total moved on an ignored byte")
  `PNGCSV_ASSERT_NOW(a_data_nonzero,
    phase == pngcsv_pkg::PH_DATA, data_remaining != '0,
    "data phase with nothing remaining")
  `PNGCSV_ASSERT_NOW(a_restart_count,
    step && item.start_candidate, res.bytes_accepted <= 32'd1,
    "restart byte counted more than once")

endmodule
